[design/odo_pkg.sv]
// ----------------------------------------------------------------------------
// odo_pkg
// shared types, constants and the arctangent table of the odometry core
// ----------------------------------------------------------------------------
package odo_pkg;

    // serial multiplier operand and product widths
    localparam int MUL_A_W = 64;
    localparam int MUL_B_W = 32;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // cordic datapath width and start vector (gain compensation, q1.30)
    localparam int CORDIC_W = 34;
    localparam logic signed [CORDIC_W-1:0] CORDIC_K = 34'sd652032874;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_L,
        S_MUL_R,
        S_DELTA,
        S_ANG,
        S_MM_CORDIC,
        S_MUL_X,
        S_MUL_Y,
        S_UPDATE
    } odo_state_t;

    // arctangent of 2^-i in binary angle units (2^32 per turn)
    function automatic logic [31:0] atan_lut(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:  v = 32'd536870912;
            5'd1:  v = 32'd316933406;
            5'd2:  v = 32'd167458907;
            5'd3:  v = 32'd85004756;
            5'd4:  v = 32'd42667331;
            5'd5:  v = 32'd21354465;
            5'd6:  v = 32'd10679838;
            5'd7:  v = 32'd5340245;
            5'd8:  v = 32'd2670163;
            5'd9:  v = 32'd1335087;
            5'd10: v = 32'd667544;
            5'd11: v = 32'd333772;
            5'd12: v = 32'd166886;
            5'd13: v = 32'd83443;
            5'd14: v = 32'd41722;
            5'd15: v = 32'd20861;
            5'd16: v = 32'd10430;
            5'd17: v = 32'd5215;
            5'd18: v = 32'd2608;
            5'd19: v = 32'd1304;
            5'd20: v = 32'd652;
            5'd21: v = 32'd326;
            5'd22: v = 32'd163;
            5'd23: v = 32'd81;
            5'd24: v = 32'd41;
            5'd25: v = 32'd20;
            5'd26: v = 32'd10;
            5'd27: v = 32'd5;
            5'd28: v = 32'd3;
            5'd29: v = 32'd1;
            5'd30: v = 32'd1;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

[design/differential_drive_odometry_core.sv]
// ----------------------------------------------------------------------------
// differential_drive_odometry_core
// wheel odometry: scaled encoder deltas, cordic heading, x/y/distance/heading
// ----------------------------------------------------------------------------
//
//  channel | ports                                   | handshake
//  --------+-----------------------------------------+-------------------
//  input   | s_left_count, s_right_count             | s_valid / s_ready
//  result  | m_x_pos, m_y_pos, m_distance, m_heading | m_valid / m_ready
//  config  | cfg_wr_en, cfg_addr, cfg_wdata          | write, no wait
//
//  one word makes six passes of the shared bit-serial multiplier, with the
//  delta state after the second, and returns to idle before the next accept;
//  the cordic runs beside the mm pass
//  m_valid is registered and rises together with the final accumulator update
//  aresetn is synchronous: state, accumulators and registers go to defaults
//  a finished word waits in the result slot while the next one is accepted;
//  only the final accumulator update waits for the slot to drain
// ----------------------------------------------------------------------------
module differential_drive_odometry_core #(
    parameter int CORDIC_STEPS = 24
) (
    input  logic               aclk,
    input  logic               aresetn,
    // config port
    input  logic               cfg_wr_en,
    input  logic [1:0]         cfg_addr,
    input  logic [31:0]        cfg_wdata,
    // input words
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [31:0] s_left_count,
    input  logic signed [31:0] s_right_count,
    // result words
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_x_pos,
    output logic signed [31:0] m_y_pos,
    output logic signed [47:0] m_distance,
    output logic signed [47:0] m_heading
);

    localparam int CW = odo_pkg::CORDIC_W;

    // register indexes
    localparam logic [1:0] REG_LEFT_RATIO  = 2'd0;
    localparam logic [1:0] REG_RIGHT_RATIO = 2'd1;
    localparam logic [1:0] REG_MM_PER_TICK = 2'd2;
    localparam logic [1:0] REG_ANG_PER_TICK = 2'd3;

    odo_pkg::odo_state_t state_reg, state_next;

    logic [19:0] left_ratio_reg, right_ratio_reg;
    logic [31:0] mm_per_tick_reg, ang_per_tick_reg;

    logic [31:0] cnt_r_reg, cnt_r_next;
    logic [47:0] lcur_reg, lcur_next, rcur_reg, rcur_next;
    logic [47:0] prev_l_reg, prev_l_next, prev_r_reg, prev_r_next;
    logic        first_reg, first_next;
    logic [47:0] dc_reg, dc_next, dd_reg, dd_next;
    logic [31:0] mm_mag_reg, mm_mag_next;
    logic        mm_neg_reg, mm_neg_next;
    logic [31:0] inc_x_reg, inc_x_next;
    logic [31:0] pos_x_reg, pos_x_next, pos_y_reg, pos_y_next;
    logic [47:0] dist_reg, dist_next, head_reg, head_next;
    logic        m_valid_reg, m_valid_next;

    // shared multiplier and cordic hookup
    logic                        mul_start;
    logic [odo_pkg::MUL_A_W-1:0] mul_a;
    logic [odo_pkg::MUL_B_W-1:0] mul_b;
    logic                        mul_busy;
    logic [odo_pkg::MUL_P_W-1:0] mul_prod;
    logic                        cor_start;
    logic                        cor_busy;
    logic signed [CW-1:0]        cos_v, sin_v;

    // datapath terms
    logic [47:0] ld, rd, dc_c, dd_c, dc_abs;
    logic [48:0] sum49, diff49, mid49;
    logic        sat_pos, sat_neg;
    logic [31:0] mm_mag_c;
    logic [CW-1:0] cos_abs, sin_abs;
    logic        inc_sgn;
    logic [63:0] p64, p64_s;
    logic [31:0] inc_c;

    odo_serial_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .busy    (mul_busy),
        .prod    (mul_prod)
    );

    odo_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cor_start),
        .ang     (mul_prod[63:32]),
        .busy    (cor_busy),
        .cos_out (cos_v),
        .sin_out (sin_v)
    );

    // config writes, values masked to register width
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_ratio_reg   <= 20'd65536;
            right_ratio_reg  <= 20'd65536;
            mm_per_tick_reg  <= 32'd16777216;
            ang_per_tick_reg <= 32'd65536;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_LEFT_RATIO:   left_ratio_reg   <= cfg_wdata[19:0];
                REG_RIGHT_RATIO:  right_ratio_reg  <= cfg_wdata[19:0];
                REG_MM_PER_TICK:  mm_per_tick_reg  <= cfg_wdata;
                REG_ANG_PER_TICK: ang_per_tick_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // wheel deltas; the first sample takes itself as the previous count
    assign ld     = lcur_reg - (first_reg ? lcur_reg : prev_l_reg);
    assign rd     = rcur_reg - (first_reg ? rcur_reg : prev_r_reg);
    assign sum49  = {rd[47], rd} + {ld[47], ld};
    assign diff49 = {rd[47], rd} - {ld[47], ld};
    assign dc_c   = sum49[48:1];
    assign dd_c   = diff49[48:1];
    // midpoint heading in ticks
    assign mid49  = {head_reg[47], head_reg} + {{2{dd_c[47]}}, dd_c[47:1]};

    assign dc_abs = dc_reg[47] ? (48'd0 - dc_reg) : dc_reg;

    // mm delta = |dc| * mm_per_tick >> 28, saturated to the q20.12 range
    assign sat_pos  = |mul_prod[95:59];
    assign sat_neg  = (|mul_prod[95:60]) || (mul_prod[59] && (|mul_prod[58:28]));
    assign mm_mag_c = dc_reg[47] ? (sat_neg ? 32'h8000_0000 : mul_prod[59:28])
                                 : (sat_pos ? 32'h7FFF_FFFF : mul_prod[59:28]);

    assign cos_abs = cos_v[CW-1] ? CW'(-cos_v) : CW'(cos_v);
    assign sin_abs = sin_v[CW-1] ? CW'(-sin_v) : CW'(sin_v);

    // signed position step from the magnitude product, floored >> 30
    assign inc_sgn = mm_neg_reg ^ ((state_reg == odo_pkg::S_MUL_X) ? cos_v[CW-1]
                                                                   : sin_v[CW-1]);
    assign p64   = mul_prod[63:0];
    assign p64_s = inc_sgn ? (64'd0 - p64) : p64;
    assign inc_c = p64_s[61:30];

    assign s_ready = (state_reg == odo_pkg::S_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= odo_pkg::S_IDLE;
            prev_l_reg  <= '0;
            prev_r_reg  <= '0;
            first_reg   <= 1'b1;
            pos_x_reg   <= '0;
            pos_y_reg   <= '0;
            dist_reg    <= '0;
            head_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            prev_l_reg  <= prev_l_next;
            prev_r_reg  <= prev_r_next;
            first_reg   <= first_next;
            pos_x_reg   <= pos_x_next;
            pos_y_reg   <= pos_y_next;
            dist_reg    <= dist_next;
            head_reg    <= head_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_r_reg  <= cnt_r_next;
        lcur_reg   <= lcur_next;
        rcur_reg   <= rcur_next;
        dc_reg     <= dc_next;
        dd_reg     <= dd_next;
        mm_mag_reg <= mm_mag_next;
        mm_neg_reg <= mm_neg_next;
        inc_x_reg  <= inc_x_next;
    end

    always_comb begin
        state_next   = state_reg;
        cnt_r_next   = cnt_r_reg;
        lcur_next    = lcur_reg;
        rcur_next    = rcur_reg;
        prev_l_next  = prev_l_reg;
        prev_r_next  = prev_r_reg;
        first_next   = first_reg;
        dc_next      = dc_reg;
        dd_next      = dd_reg;
        mm_mag_next  = mm_mag_reg;
        mm_neg_next  = mm_neg_reg;
        inc_x_next   = inc_x_reg;
        pos_x_next   = pos_x_reg;
        pos_y_next   = pos_y_reg;
        dist_next    = dist_reg;
        head_next    = head_reg;
        m_valid_next = m_valid_reg && !m_ready;
        mul_start    = 1'b0;
        mul_a        = '0;
        mul_b        = '0;
        cor_start    = 1'b0;

        case (state_reg)
            odo_pkg::S_IDLE: begin
                if (s_valid) begin
                    // left scaled count: sign-extended count times ratio
                    cnt_r_next = s_right_count;
                    mul_start  = 1'b1;
                    mul_a      = {{32{s_left_count[31]}}, s_left_count};
                    mul_b      = {12'd0, left_ratio_reg};
                    state_next = odo_pkg::S_MUL_L;
                end
            end
            odo_pkg::S_MUL_L: begin
                if (!mul_busy) begin
                    lcur_next  = mul_prod[47:0];
                    mul_start  = 1'b1;
                    mul_a      = {{32{cnt_r_reg[31]}}, cnt_r_reg};
                    mul_b      = {12'd0, right_ratio_reg};
                    state_next = odo_pkg::S_MUL_R;
                end
            end
            odo_pkg::S_MUL_R: begin
                if (!mul_busy) begin
                    rcur_next  = mul_prod[47:0];
                    state_next = odo_pkg::S_DELTA;
                end
            end
            odo_pkg::S_DELTA: begin
                dc_next     = dc_c;
                dd_next     = dd_c;
                prev_l_next = lcur_reg;
                prev_r_next = rcur_reg;
                first_next  = 1'b0;
                // binary angle = bits 63:32 of midpoint times angle_per_tick
                mul_start   = 1'b1;
                mul_a       = {{15{mid49[48]}}, mid49};
                mul_b       = ang_per_tick_reg;
                state_next  = odo_pkg::S_ANG;
            end
            odo_pkg::S_ANG: begin
                if (!mul_busy) begin
                    // cordic and mm conversion run side by side
                    cor_start  = 1'b1;
                    mul_start  = 1'b1;
                    mul_a      = {16'd0, dc_abs};
                    mul_b      = mm_per_tick_reg;
                    state_next = odo_pkg::S_MM_CORDIC;
                end
            end
            odo_pkg::S_MM_CORDIC: begin
                if (!mul_busy && !cor_busy) begin
                    mm_mag_next = mm_mag_c;
                    mm_neg_next = dc_reg[47];
                    mul_start   = 1'b1;
                    mul_a       = {32'd0, mm_mag_c};
                    mul_b       = cos_abs[31:0];
                    state_next  = odo_pkg::S_MUL_X;
                end
            end
            odo_pkg::S_MUL_X: begin
                if (!mul_busy) begin
                    inc_x_next = inc_c;
                    mul_start  = 1'b1;
                    mul_a      = {32'd0, mm_mag_reg};
                    mul_b      = sin_abs[31:0];
                    state_next = odo_pkg::S_MUL_Y;
                end
            end
            odo_pkg::S_MUL_Y: begin
                if (!mul_busy && (!m_valid_reg || m_ready)) begin
                    // commit once the result slot is free
                    pos_x_next   = pos_x_reg + inc_x_reg;
                    pos_y_next   = pos_y_reg + inc_c;
                    dist_next    = dist_reg + dc_reg;
                    head_next    = head_reg + dd_reg;
                    m_valid_next = 1'b1;
                    state_next   = odo_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = odo_pkg::S_IDLE;
            end
        endcase
    end

    // accumulators only move when the slot is free, so they drive the word
    assign m_valid    = m_valid_reg;
    assign m_x_pos    = pos_x_reg;
    assign m_y_pos    = pos_y_reg;
    assign m_distance = dist_reg;
    assign m_heading  = head_reg;

endmodule

[design/odo_serial_mul.sv]
// ----------------------------------------------------------------------------
// odo_serial_mul
// unsigned shift-add multiplier, one multiplier bit per cycle
// ----------------------------------------------------------------------------
module odo_serial_mul (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [odo_pkg::MUL_A_W-1:0]   a,
    input  logic [odo_pkg::MUL_B_W-1:0]   b,
    output logic                          busy,
    output logic [odo_pkg::MUL_P_W-1:0]   prod
);

    localparam int CW = $clog2(odo_pkg::MUL_B_W);
    localparam logic [CW-1:0] LAST = CW'(odo_pkg::MUL_B_W - 1);

    logic [odo_pkg::MUL_A_W-1:0] a_reg;
    logic [odo_pkg::MUL_A_W-1:0] hi_reg;
    logic [odo_pkg::MUL_B_W-1:0] lo_reg;
    logic [CW-1:0]               cnt_reg;
    logic                        busy_reg;
    logic [odo_pkg::MUL_A_W:0]   sum;

    // partial sum, low product bits shift in as multiplier bits shift out
    assign sum = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, a_reg} : '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == LAST) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            a_reg  <= a;
            hi_reg <= '0;
            lo_reg <= b;
        end else if (busy_reg) begin
            hi_reg <= sum[odo_pkg::MUL_A_W:1];
            lo_reg <= {sum[0], lo_reg[odo_pkg::MUL_B_W-1:1]};
        end
    end

    assign busy = busy_reg;
    assign prod = {hi_reg, lo_reg};

endmodule

[design/odo_cordic.sv]
// ----------------------------------------------------------------------------
// odo_cordic
// iterative rotation-mode cordic, one micro-rotation per cycle
// ----------------------------------------------------------------------------
module odo_cordic #(
    parameter int STEPS = 24
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  start,
    input  logic [31:0]                           ang,
    output logic                                  busy,
    output logic signed [odo_pkg::CORDIC_W-1:0]   cos_out,
    output logic signed [odo_pkg::CORDIC_W-1:0]   sin_out
);

    localparam int N = (STEPS > 32) ? 32 : STEPS;
    localparam logic [4:0] LAST = 5'(N - 1);
    localparam int W = odo_pkg::CORDIC_W;

    logic signed [W-1:0] x_reg, y_reg, z_reg;
    logic signed [W-1:0] xs, ys, at;
    logic [4:0]          i_reg;
    logic                busy_reg;
    logic                flip_reg;
    logic                flip;
    logic [31:0]         ang_f;

    // fold into the right half plane, a fold negates both results
    assign flip  = ang[31] ^ ang[30];
    assign ang_f = flip ? (ang ^ 32'h8000_0000) : ang;

    assign xs = x_reg >>> i_reg;
    assign ys = y_reg >>> i_reg;
    assign at = W'(odo_pkg::atan_lut(i_reg));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            i_reg    <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            i_reg    <= '0;
        end else if (busy_reg) begin
            i_reg <= i_reg + 1'b1;
            if (i_reg == LAST) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            x_reg    <= odo_pkg::CORDIC_K;
            y_reg    <= '0;
            z_reg    <= W'($signed(ang_f));
            flip_reg <= flip;
        end else if (busy_reg) begin
            if (!z_reg[W-1]) begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - at;
            end else begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + at;
            end
        end
    end

    assign busy    = busy_reg;
    assign cos_out = flip_reg ? -x_reg : x_reg;
    assign sin_out = flip_reg ? -y_reg : y_reg;

endmodule

[test/differential_drive_odometry_core_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// differential_drive_odometry_core_checker
// watches both channels, predicts the pose words and compares them
// ----------------------------------------------------------------------------
module differential_drive_odometry_core_checker #(
    parameter int CORDIC_STEPS = 24
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [1:0]         cfg_addr,
    input  logic [31:0]        cfg_wdata,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic signed [31:0] s_left_count,
    input  logic signed [31:0] s_right_count,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic signed [31:0] m_x_pos,
    input  logic signed [31:0] m_y_pos,
    input  logic signed [47:0] m_distance,
    input  logic signed [47:0] m_heading,
    output int                 fail_count,
    output int                 pending_poses
);

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [47:0] travel;
        logic [47:0] head;
    } pose_t;

    localparam int CORDIC_REG_INDEX_L = 0;
    localparam int CORDIC_REG_INDEX_R = 1;
    localparam int CORDIC_REG_INDEX_MM = 2;
    localparam int CORDIC_REG_INDEX_ANG = 3;

    // arctangent of 2^-i, binary angle units
    localparam logic [31:0] ATAN [32] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
        32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
        32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
        32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0};

    logic [19:0] l_ratio, r_ratio;
    logic [31:0] mm_scale, ang_scale;
    logic [47:0] last_l, last_r, dist_sum, head_sum;
    logic [31:0] x_sum, y_sum;
    logic        fresh;
    pose_t       pose_q[$];

    // cos/sin of a binary angle, q1.30
    function automatic void rotate(input logic [31:0] ang,
                                   output logic signed [63:0] c,
                                   output logic signed [63:0] s);
        logic signed [63:0] x, y, z, xs, ys;
        logic flip;
        int n;
        flip = ang[31] ^ ang[30];
        n = CORDIC_STEPS > 32 ? 32 : CORDIC_STEPS;
        if (flip) ang = ang - 32'h8000_0000;
        x = 64'sd652032874;
        y = 0;
        z = 64'(signed'(ang));
        for (int i = 0; i < n; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                x = x - ys; y = y + xs; z = z - ATAN[i];
            end else begin
                x = x + ys; y = y - xs; z = z + ATAN[i];
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    // signed q.16 ticks to saturated q20.12 mm
    function automatic logic signed [63:0] ticks_to_mm(input logic signed [63:0] dc);
        logic [63:0] a, r;
        logic n;
        n = dc < 0;
        a = n ? -dc : dc;
        r = ((a >> 16) * mm_scale + (((a & 64'hFFFF) * mm_scale) >> 16)) >> 12;
        if (!n && r > 64'h7FFF_FFFF) r = 64'h7FFF_FFFF;
        if (n && r > 64'h8000_0000) r = 64'h8000_0000;
        return n ? -signed'(r) : signed'(r);
    endfunction

    task automatic advance_pose(input logic signed [31:0] lc, input logic signed [31:0] rc);
        logic [47:0] lcur, rcur;
        logic signed [63:0] ld, rd, dc, dd, mid, mm, c, s, px, py;
        logic [63:0] prod;
        pose_t p;
        lcur = 48'(64'(lc) * 64'(l_ratio));
        rcur = 48'(64'(rc) * 64'(r_ratio));
        if (fresh) begin
            last_l = lcur; last_r = rcur; fresh = 1'b0;
        end
        ld = 64'(signed'(48'(lcur - last_l)));
        rd = 64'(signed'(48'(rcur - last_r)));
        last_l = lcur; last_r = rcur;
        dc = (rd + ld) >>> 1;
        dd = (rd - ld) >>> 1;
        mid = 64'(signed'(head_sum)) + (dd >>> 1);
        prod = mid * 64'(ang_scale);
        rotate(prod[63:32], c, s);
        mm = ticks_to_mm(dc);
        px = (mm * c) >>> 30;
        py = (mm * s) >>> 30;
        x_sum = x_sum + px[31:0];
        y_sum = y_sum + py[31:0];
        dist_sum = dist_sum + dc[47:0];
        head_sum = head_sum + dd[47:0];
        p.x = x_sum; p.y = y_sum; p.travel = dist_sum; p.head = head_sum;
        pose_q.push_back(p);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            l_ratio = 20'd65536;
            r_ratio = 20'd65536;
            mm_scale = 32'd16777216;
            ang_scale = 32'd65536;
            last_l = '0; last_r = '0; dist_sum = '0; head_sum = '0;
            x_sum = '0; y_sum = '0; fresh = 1'b1;
            pose_q.delete();
            fail_count <= 0;
        end else begin
            if (cfg_wr_en) begin
                case (int'(cfg_addr))
                    CORDIC_REG_INDEX_L: l_ratio = cfg_wdata[19:0];
                    CORDIC_REG_INDEX_R: r_ratio = cfg_wdata[19:0];
                    CORDIC_REG_INDEX_MM: mm_scale = cfg_wdata;
                    CORDIC_REG_INDEX_ANG: ang_scale = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_valid && s_ready) advance_pose(s_left_count, s_right_count);
            if (m_valid && m_ready) begin
                if (pose_q.size() == 0) begin
                    $display("%0t: unexpected pose word x=%h", $time, m_x_pos);
                    fail_count <= fail_count + 1;
                end else begin
                    pose_t e;
                    e = pose_q.pop_front();
                    if (e.x !== m_x_pos || e.y !== m_y_pos ||
                        e.travel !== m_distance || e.head !== m_heading) begin
                        $display("%0t: pose mismatch exp x=%h y=%h d=%h h=%h got x=%h y=%h d=%h h=%h",
                                 $time, e.x, e.y, e.travel, e.head,
                                 m_x_pos, m_y_pos, m_distance, m_heading);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

    assign pending_poses = pose_q.size();

endmodule

[test/differential_drive_odometry_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// differential_drive_odometry_core_tb
// directed and random encoder words across several register settings; the
// checker predicts every pose word and counts mismatches
// ----------------------------------------------------------------------------
module differential_drive_odometry_core_tb;

    localparam int REG_LEFT = 0;
    localparam int REG_RIGHT = 1;
    localparam int REG_MM = 2;
    localparam int REG_ANGLE = 3;
    localparam int STALL_LIMIT = 20000;  // well above one word's processing plus long stalls

    logic               aclk;
    logic               aresetn;
    logic               cfg_wr_en;
    logic [1:0]         cfg_addr;
    logic [31:0]        cfg_wdata;
    logic               s_valid, s_ready;
    logic signed [31:0] s_left_count, s_right_count;
    logic               m_valid, m_ready;
    logic signed [31:0] m_x_pos, m_y_pos;
    logic signed [47:0] m_distance, m_heading;
    int                 fail_count, pending_poses;
    int                 quiet_cycles;
    bit                 calm;          // no idling in the last stretch
    int                 m_hold;
    logic [31:0]        enc_l, enc_r;  // running wheel counts

    differential_drive_odometry_core dut (.*);

    differential_drive_odometry_core_checker chk (.*);

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // result side: random stall bursts unless calm
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            m_hold <= 0;
        end else if (m_hold > 0) begin
            m_hold <= m_hold - 1;
            m_ready <= 1'b0;
        end else if (!calm && $urandom_range(0, 5) == 0) begin
            m_hold <= $urandom_range(1, 15) - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // watchdog: cycles with no word moving on either side
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("differential_drive_odometry_core_tb: FAIL");
            $finish;
        end
    end

    task automatic write_reg(input int idx, input logic [31:0] val);
        cfg_wr_en <= 1'b1;
        cfg_addr <= 2'(idx);
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // one encoder word, with an optional idle burst in front
    task automatic send_word(input logic [31:0] l, input logic [31:0] r);
        if (!calm && $urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 15)) @(posedge aclk);
        s_valid <= 1'b1;
        s_left_count <= l;
        s_right_count <= r;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        s_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // wait for every pose word, then let the core settle before writes
    task automatic drain();
        while (pending_poses != 0) @(posedge aclk);
        repeat (250) @(posedge aclk);
    endtask

    // encoder motion: mostly small steps, sometimes large jumps or full noise
    task automatic random_moves(input int n);
        int k;
        for (int i = 0; i < n; i++) begin
            k = $urandom_range(0, 19);
            if (k == 0) begin
                enc_l = $urandom; enc_r = $urandom;
            end else if (k < 3) begin
                enc_l = enc_l + $urandom_range(0, 1 << 20) - (1 << 19);
                enc_r = enc_r + $urandom_range(0, 1 << 20) - (1 << 19);
            end else begin
                enc_l = enc_l + $urandom_range(0, 400) - 200;
                enc_r = enc_r + $urandom_range(0, 400) - 200;
            end
            send_word(enc_l, enc_r);
        end
    endtask

    initial begin
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_addr = '0;
        cfg_wdata = '0;
        s_valid = 1'b0;
        s_left_count = '0;
        s_right_count = '0;
        calm = 1'b0;
        enc_l = '0;
        enc_r = '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: first sample, field extremes, straight, spin, huge travel
        send_word(32'sd1000, -32'sd1000);
        send_word(32'sd1100, -32'sd900);
        send_word(32'sd1200, -32'sd1000);
        send_word(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_word(32'h8000_0000, 32'h8000_0000);
        send_word(32'h8000_0000, 32'h7FFF_FFFF);
        send_word(32'h7FFF_FFFF, 32'h8000_0000);
        send_word(32'hFFFF_FFFF, 32'h0);
        send_word(32'h0, 32'h0);
        send_word(32'h5555_5555, 32'hAAAA_AAAA);
        send_word(32'hAAAA_AAAA, 32'h5555_5555);
        drain();

        // extremes of every register, including an out-of-range style mask
        write_reg(REG_LEFT, 32'hFFFF_FFFF);
        write_reg(REG_RIGHT, 32'h000F_FFFF);
        write_reg(REG_MM, 32'hFFFF_FFFF);
        write_reg(REG_ANGLE, 32'hFFFF_FFFF);
        send_word(32'sd0, 32'sd0);
        send_word(32'sd40000, -32'sd40000);
        send_word(32'h7FFF_FFFF, 32'h8000_0000);
        send_word(32'sd12345, 32'sd54321);
        drain();
        write_reg(REG_LEFT, 32'h0);
        write_reg(REG_RIGHT, 32'h0);
        write_reg(REG_MM, 32'h0);
        write_reg(REG_ANGLE, 32'h0);
        send_word(32'sd77, -32'sd5);
        send_word(32'sd999, 32'sd3);
        drain();

        // random phases over several settings
        for (int ph = 0; ph < 6; ph++) begin
            write_reg(REG_LEFT, $urandom_range(60000, 71000));
            write_reg(REG_RIGHT, ph == 5 ? 32'hF_FFFF : $urandom_range(60000, 71000));
            write_reg(REG_MM, ph == 4 ? $urandom : $urandom_range(1 << 20, 1 << 26));
            write_reg(REG_ANGLE, ph == 3 ? $urandom : $urandom_range(1 << 12, 1 << 24));
            if (ph == 5) calm = 1'b1;
            random_moves(300);
            drain();
        end

        repeat (300) @(posedge aclk);
        if (fail_count == 0 && pending_poses == 0)
            $display("differential_drive_odometry_core_tb: PASS");
        else
            $display("differential_drive_odometry_core_tb: FAIL");
        $finish;
    end

endmodule
